>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the hash table modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define LPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every clock edge, reset included
`define LPHT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// types and constants of the linear probing hash table
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

  localparam int SLOTS   = 1024;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int KEY_W   = 64;
  localparam int PAY_W   = 32;
  localparam int CFG_W   = 11;
  localparam int DIV_STEPS = KEY_W;
  localparam int DCNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_ZERO_KEY  = 2'd3
  } status_t;

  typedef struct packed {
    logic    clr_step;
    logic    load_in;
    logic    mod_start;
    logic    mod_sel_kj;
    logic    set_i_rem;
    logic    step_i;
    logic    rd_sel_j;
    logic    wr_ins;
    logic    latch_hit;
    logic    wr_del_i;
    logic    latch_kj;
    logic    wr_move;
    logic    wr_clr_j;
    logic    step_j;
    logic    res_load;
    status_t res_status;
    logic    res_slot_en;
    logic    res_found_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_t  op;
    logic key_zero;
    logic mod_done;
    logic slot_empty;
    logic key_hit;
    logic sweep_end;
    logic c_end;
    logic move_ok;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> src/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open-addressing hash table, linear probing, backward-shift removal
// ----------------------------------------------------------------------------
// After reset the key store is swept to empty, one slot a cycle, during
// which no transaction is taken on s_* (cfg writes are taken).
// Each operation computes key mod slots_in_use (clamped to 2..1024) in a
// bit-serial remainder unit, then probes slot by slot, each probe a read
// state and a check state, through the registered read port of the key ram.
// Remove then visits every later entry of the cluster, recomputes its home
// slot in the remainder unit and moves it back into the hole when it may.
// Zero keys and the unused operation code answer without any probing.
`default_nettype none

module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,  // key[63:0], payload[95:64]
  input  wire logic [1:0]   s_tuser,  // operation[1:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [47:0]  m_tdata,  // slot_index[9:0], found_payload[41:10], zero
  output logic      [1:0]   m_tuser,  // status[1:0]
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [10:0]  cfg_data  // slots_in_use
);

  cmd_t             cmd;
  sts_t             sts;
  status_t          out_status;
  logic [IDX_W-1:0] out_slot;
  logic [PAY_W-1:0] out_payload;

  assign cfg_ready = 1'b1;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpht_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (s_tuser),
    .in_key      (s_tdata[63:0]),
    .in_payload  (s_tdata[95:64]),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_value   (cfg_data),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .out_payload (out_payload)
  );

  assign m_tuser = out_status;
  assign m_tdata = {6'd0, out_payload, out_slot};

endmodule

`default_nettype wire

>>> src/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_mod
  import lpht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [KEY_W-1:0] dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  done,
  output logic      [IDX_W-1:0] remainder
);

  logic [KEY_W-1:0]  shreg;
  logic [CNT_W-1:0]  rem;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    rem_step;

  always_comb begin
    trial = {rem, shreg[KEY_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_step = trial - {1'b0, divisor};
    end else begin
      rem_step = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      rem  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        shreg <= dividend;
        rem   <= '0;
        cnt   <= DCNT_W'(DIV_STEPS);
      end else if (busy) begin
        shreg <= {shreg[KEY_W-2:0], 1'b0};
        rem   <= rem_step[CNT_W-1:0];
        cnt   <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[IDX_W-1:0];

endmodule

`default_nettype wire

>>> src/lpht_datapath.sv
// ----------------------------------------------------------------------------
// lpht_datapath
// key and payload stores, probe registers, remainder unit and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpht_datapath
  import lpht_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  input  wire logic [1:0]       in_op,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire logic [PAY_W-1:0] in_payload,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output status_t               out_status,
  output logic      [IDX_W-1:0] out_slot,
  output logic      [PAY_W-1:0] out_payload
);

  logic [CFG_W-1:0] slots_in_use;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_clamped;
  op_t              op_q;
  logic [KEY_W-1:0] key_q;
  logic [PAY_W-1:0] pay_q;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] hole;
  logic [CNT_W-1:0] c;
  logic [IDX_W-1:0] hit;
  logic [PAY_W-1:0] hit_pay;
  logic [KEY_W-1:0] kj;
  logic [PAY_W-1:0] pj;

  logic             key_we;
  logic [IDX_W-1:0] key_waddr;
  logic [KEY_W-1:0] key_wdata;
  logic [KEY_W-1:0] key_rdata;
  logic             pay_we;
  logic [IDX_W-1:0] pay_waddr;
  logic [PAY_W-1:0] pay_wdata;
  logic [PAY_W-1:0] pay_rdata;
  logic [IDX_W-1:0] raddr;

  logic             mod_done;
  logic [IDX_W-1:0] home;
  logic [CNT_W-1:0] c_inc;
  logic [IDX_W-1:0] i_next;
  logic [IDX_W-1:0] j_next;
  logic [CNT_W:0]   dis;
  logic [CNT_W:0]   half;

  always_comb begin
    if (slots_in_use < CFG_W'(2)) begin
      n_clamped = CNT_W'(2);
    end else if (32'(slots_in_use) > SLOTS) begin
      n_clamped = CNT_W'(SLOTS);
    end else begin
      n_clamped = CNT_W'(slots_in_use);
    end
  end

  lpht_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start),
    .dividend  (cmd.mod_sel_kj ? key_rdata : key_q),
    .divisor   (n),
    .done      (mod_done),
    .remainder (home)
  );

  assign c_inc  = c + 1'b1;
  assign i_next = ({1'b0, i} + 1'b1 >= n) ? '0 : i + 1'b1;
  assign j_next = ({1'b0, j} + 1'b1 >= n) ? '0 : j + 1'b1;
  assign half   = {2'b00, n[CNT_W-1:1]};

  always_comb begin
    dis = {2'b00, home} - {2'b00, hole};
    if ($signed(dis) < -$signed(half)) begin
      dis = dis + {1'b0, n};
    end else if ($signed(dis) > $signed(half)) begin
      dis = dis - {1'b0, n};
    end
  end

  always_comb begin
    key_we    = cmd.clr_step | cmd.wr_ins | cmd.wr_del_i | cmd.wr_move | cmd.wr_clr_j;
    key_waddr = i;
    key_wdata = '0;
    if (cmd.wr_move) begin
      key_waddr = hole;
      key_wdata = kj;
    end else if (cmd.wr_clr_j) begin
      key_waddr = j;
    end else if (cmd.wr_ins) begin
      key_wdata = key_q;
    end
    pay_we    = cmd.wr_ins | cmd.wr_move;
    pay_waddr = cmd.wr_move ? hole : i;
    pay_wdata = cmd.wr_move ? pj : pay_q;
  end

  assign raddr = cmd.rd_sel_j ? j : i;

  lpht_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  lpht_ram #(.WIDTH(PAY_W), .DEPTH(SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (pay_we),
    .waddr (pay_waddr),
    .wdata (pay_wdata),
    .raddr (raddr),
    .rdata (pay_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= CFG_RESET;
      i            <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_value;
      end
      if (cmd.clr_step) begin
        i <= i + 1'b1;
      end else if (cmd.set_i_rem) begin
        i <= home;
      end else if (cmd.step_i) begin
        i <= i_next;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q  <= op_t'(in_op);
      key_q <= in_key;
      pay_q <= in_payload;
      n     <= n_clamped;
    end
    if (cmd.set_i_rem) begin
      c <= '0;
    end else if (cmd.step_i) begin
      c <= c_inc;
    end else if (cmd.wr_del_i) begin
      c <= CNT_W'(1);
    end else if (cmd.step_j) begin
      c <= c_inc;
    end
    if (cmd.latch_hit) begin
      hit     <= i;
      hit_pay <= pay_rdata;
    end
    if (cmd.wr_del_i) begin
      hole <= i;
      j    <= i_next;
    end else begin
      if (cmd.wr_clr_j) begin
        hole <= j;
      end
      if (cmd.step_j) begin
        j <= j_next;
      end
    end
    if (cmd.latch_kj) begin
      kj <= key_rdata;
      pj <= pay_rdata;
    end
    if (cmd.res_load) begin
      out_status  <= cmd.res_status;
      out_slot    <= cmd.res_slot_en ? hit : '0;
      out_payload <= cmd.res_found_en ? hit_pay : '0;
    end
  end

  always_comb begin
    sts.clr_last   = (i == IDX_W'(SLOTS - 1));
    sts.op         = op_q;
    sts.key_zero   = (key_q == '0);
    sts.mod_done   = mod_done;
    sts.slot_empty = (key_rdata == '0);
    sts.key_hit    = (key_rdata == key_q);
    sts.sweep_end  = (c_inc >= n);
    sts.c_end      = (c >= n);
    sts.move_ok    = dis[CNT_W] | (dis == '0);
    sts.out_free   = !out_valid || out_ready;
  end

  `LPHT_ASSERT(a_no_zero_insert, cmd.wr_ins |-> key_q != '0, "zero key written on insert")
  `LPHT_ASSERT(a_mod_latency, cmd.mod_start |=> !mod_done, "remainder done too early")

endmodule

`default_nettype wire

>>> src/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// sequencer for clearing, probing, insert, find and backward-shift removal
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lpht_ctrl
  import lpht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [11:0] {
    S_CLEAR  = 12'b0000_0000_0001,
    S_IDLE   = 12'b0000_0000_0010,
    S_DECODE = 12'b0000_0000_0100,
    S_MOD    = 12'b0000_0000_1000,
    S_RD     = 12'b0000_0001_0000,
    S_CHK    = 12'b0000_0010_0000,
    S_RM_RD  = 12'b0000_0100_0000,
    S_RM_CHK = 12'b0000_1000_0000,
    S_RM_MOD = 12'b0001_0000_0000,
    S_RM_DIS = 12'b0010_0000_0000,
    S_RM_CLR = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t  state, state_next;
  status_t code, code_next;
  logic    slot_en, slot_en_next;
  logic    found_en, found_en_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      code     <= ST_OK;
      slot_en  <= 1'b0;
      found_en <= 1'b0;
    end else begin
      state    <= state_next;
      code     <= code_next;
      slot_en  <= slot_en_next;
      found_en <= found_en_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    code_next     = code;
    slot_en_next  = slot_en;
    found_en_next = found_en;
    cmd           = '0;
    cmd.res_status = code;
    cmd.res_slot_en = slot_en;
    cmd.res_found_en = found_en;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        slot_en_next  = 1'b0;
        found_en_next = 1'b0;
        if (sts.op == OP_UNUSED) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_DONE;
        end else if (sts.key_zero) begin
          code_next  = ST_ZERO_KEY;
          state_next = S_DONE;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          cmd.set_i_rem = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        if (sts.op == OP_INSERT && sts.slot_empty) begin
          cmd.wr_ins    = 1'b1;
          cmd.latch_hit = 1'b1;
          code_next     = ST_OK;
          slot_en_next  = 1'b1;
          state_next    = S_DONE;
        end else if (sts.op != OP_INSERT && sts.slot_empty) begin
          code_next  = ST_NOT_FOUND;
          state_next = S_DONE;
        end else if (sts.op != OP_INSERT && sts.key_hit) begin
          cmd.latch_hit = 1'b1;
          code_next     = ST_OK;
          slot_en_next  = 1'b1;
          if (sts.op == OP_FIND) begin
            found_en_next = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.wr_del_i = 1'b1;
            state_next   = S_RM_RD;
          end
        end else if (sts.sweep_end) begin
          code_next  = (sts.op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
          state_next = S_DONE;
        end else begin
          cmd.step_i = 1'b1;
          state_next = S_RD;
        end
      end
      S_RM_RD: begin
        cmd.rd_sel_j = 1'b1;
        if (sts.c_end) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (sts.slot_empty) begin
          state_next = S_DONE;
        end else begin
          cmd.latch_kj = 1'b1;
          state_next   = S_RM_MOD;
        end
      end
      S_RM_MOD: begin
        if (!cmd.mod_start && sts.mod_done) begin
          state_next = S_RM_DIS;
        end
      end
      S_RM_DIS: begin
        if (sts.move_ok) begin
          cmd.wr_move = 1'b1;
          state_next  = S_RM_CLR;
        end else begin
          cmd.step_j = 1'b1;
          state_next = S_RM_RD;
        end
      end
      S_RM_CLR: begin
        cmd.wr_clr_j = 1'b1;
        cmd.step_j   = 1'b1;
        state_next   = S_RM_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
    if (state == S_RM_CHK && !sts.slot_empty) begin
      cmd.mod_start  = 1'b1;
    end
    cmd.mod_sel_kj = (state == S_RM_CHK) || (state == S_RM_MOD);
  end

  `LPHT_ASSERT(a_no_result_overwrite, cmd.res_load |-> sts.out_free, "pending result overwritten")
  `LPHT_ASSERT(a_accept_only_idle, cmd.load_in |=> state == S_DECODE, "accept outside idle")

endmodule

`default_nettype wire

>>> dv/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// drives insert, find, remove and unused-operation transactions, zero keys
// included, into the hash table under a range of slot counts and checks
// every answer against a table model kept in the bench, with random idle
// bursts on both stream sides for most of the slot counts

module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  typedef struct packed {
    status_t     st;
    logic [9:0]  slot;
    logic [31:0] pay;
  } answer_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [10:0]  cfg_data = '0;

  logic [63:0]  model_keys [SLOTS];
  logic [31:0]  model_pays [SLOTS];
  logic [10:0]  model_slots;
  answer_t      pending_answers [$];
  logic [63:0]  key_pool [$];
  int           errors = 0;
  int           stall_cycles = 0;
  bit           idle_on = 1'b1;

  linear_probe_hash_table uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic answer_t apply_op(op_t op, logic [63:0] key, logic [31:0] pay);
    answer_t r;
    int n, i, j, c, half;
    longint dis;
    bit hit;
    n = (model_slots < 2) ? 2 : (model_slots > SLOTS) ? SLOTS : int'(model_slots);
    r = '{ST_NOT_FOUND, 10'd0, 32'd0};
    hit = 1'b0;
    if (op == OP_UNUSED) begin
    end else if (key == 64'd0) begin
      r.st = ST_ZERO_KEY;
    end else if (op == OP_INSERT) begin
      r.st = ST_FULL;
      i = int'(key % 64'(n));
      for (c = 0; c < n; c++) begin
        if (model_keys[i] == 64'd0) begin
          model_keys[i] = key;
          model_pays[i] = pay;
          r.st = ST_OK;
          r.slot = i[9:0];
          break;
        end
        i = (i + 1 >= n) ? 0 : i + 1;
      end
    end else begin
      i = int'(key % 64'(n));
      for (c = 0; c < n; c++) begin
        if (model_keys[i] == 64'd0) break;
        if (model_keys[i] == key) begin
          hit = 1'b1;
          break;
        end
        i = (i + 1 >= n) ? 0 : i + 1;
      end
      if (hit) begin
        r.st = ST_OK;
        r.slot = i[9:0];
        if (op == OP_FIND) begin
          r.pay = model_pays[i];
        end else begin
          half = n / 2;
          model_keys[i] = 64'd0;
          j = (i + 1 >= n) ? 0 : i + 1;
          for (c = 1; c < n && model_keys[j] != 64'd0; c++) begin
            dis = longint'(model_keys[j] % 64'(n)) - longint'(i);
            if (dis < -half) dis += n;
            if (dis > half) dis -= n;
            if (dis <= 0) begin
              model_keys[i] = model_keys[j];
              model_pays[i] = model_pays[j];
              model_keys[j] = 64'd0;
              i = j;
            end
            j = (j + 1 >= n) ? 0 : j + 1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    answer_t want;
    if (m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected transaction", {m_tuser, m_tdata}, 64'd0);
      end else begin
        want = pending_answers.pop_front();
        if (m_tuser != want.st) report_mismatch("status", m_tuser, want.st);
        if (m_tdata[9:0] != want.slot) report_mismatch("slot_index", m_tdata[9:0], want.slot);
        if (m_tdata[41:10] != want.pay)
          report_mismatch("found_payload", m_tdata[41:10], want.pay);
        if (m_tdata[47:42] != 6'd0) report_mismatch("pad bits", m_tdata[47:42], 64'd0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver backpressure
  initial begin
    @(negedge clk);
    m_tready = 1'b1;
    forever begin
      repeat ($urandom_range(1, 40)) @(negedge clk);
      if (idle_on && $urandom_range(0, 1)) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        m_tready = 1'b1;
      end
    end
  end

  task automatic send_item(op_t op, logic [63:0] key, logic [31:0] pay);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {pay, key};
    do @(posedge clk); while (!s_tready);
    pending_answers.push_back(apply_op(op, key, pay));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic drain;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_slots(logic [10:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    model_slots = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_basic_ops;
    send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 64'd1, 32'd0);
    send_item(OP_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_item(OP_FIND, 64'd1, 32'hFFFF_FFFF);
    send_item(OP_FIND, 64'd2, 32'd0);
    send_item(OP_REMOVE, 64'd2, 32'd0);
    send_item(OP_INSERT, 64'd0, 32'h1234_5678);
    send_item(OP_FIND, 64'd0, 32'd0);
    send_item(OP_REMOVE, 64'd0, 32'd0);
    send_item(OP_UNUSED, 64'hDEAD_BEEF_0000_0001, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 64'd1, 32'd0);
    send_item(OP_FIND, 64'd1, 32'd0);
  endtask

  task automatic test_shift_and_full;
    write_slots(11'd4);
    send_item(OP_INSERT, 64'd4, 32'hA);
    send_item(OP_INSERT, 64'd8, 32'hB);
    send_item(OP_INSERT, 64'd7, 32'hC);
    send_item(OP_INSERT, 64'd11, 32'hD);
    send_item(OP_REMOVE, 64'd4, 32'd0);
    send_item(OP_FIND, 64'd8, 32'd0);
    send_item(OP_REMOVE, 64'd7, 32'd0);
    send_item(OP_FIND, 64'd11, 32'd0);
    write_slots(11'd2);
    send_item(OP_INSERT, 64'd6, 32'h1);
    send_item(OP_INSERT, 64'd9, 32'h2);
    send_item(OP_INSERT, 64'd10, 32'h3);
    send_item(OP_FIND, 64'd5, 32'd0);
  endtask

  function automatic logic [63:0] pick_key(int n);
    logic [63:0] k;
    k = {$urandom, $urandom};
    if ($urandom_range(0, 1))
      k = (k / 64'(n)) * 64'(n) + 64'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) k = 64'($urandom_range(1, 4 * n));
    if (k == 64'd0) k = 64'd1;
    return k;
  endfunction

  task automatic test_random;
    logic [10:0] settings [12] = '{11'd8, 11'd2, 11'd3, 11'd0, 11'd16, 11'd1024,
                                   11'd5, 11'd1, 11'd31, 11'd2047, 11'd64, 11'd1025};
    int n, w, p;
    logic [63:0] k;
    for (p = 0; p < 12; p++) begin
      write_slots(settings[p]);
      n = (settings[p] < 2) ? 2 : (settings[p] > SLOTS) ? SLOTS : int'(settings[p]);
      key_pool.delete();
      repeat (n < 12 ? n + 4 : 16) key_pool.push_back(pick_key(n));
      if (p == 9) idle_on = 1'b0;
      repeat (88) begin
        w = $urandom_range(0, 99);
        k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (w < 40) send_item(OP_INSERT, k, $urandom);
        else if (w < 68) send_item(OP_FIND, k, $urandom);
        else if (w < 93) send_item(OP_REMOVE, k, $urandom);
        else if (w < 95) send_item(op_t'($urandom_range(0, 2)), 64'd0, $urandom);
        else if (w < 97) send_item(OP_UNUSED, {$urandom, $urandom}, $urandom);
        else send_item(op_t'($urandom_range(1, 2)), {$urandom, $urandom}, $urandom);
      end
    end
  endtask

  initial begin
    foreach (model_keys[i]) begin
      model_keys[i] = 64'd0;
      model_pays[i] = 32'd0;
    end
    model_slots = CFG_RESET;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    test_basic_ops();
    test_shift_and_full();
    test_random();
    drain();
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
